### rtl/core/spj_pkg.sv
// Shared types and constants for the stereo pose projection Jacobian core.
// Depends on nothing; every file in rtl/core imports it.
`timescale 1ns / 1ps

package spj_pkg;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
  } spj_in_word_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] d_rot_x;
    logic signed [31:0] d_rot_y;
    logic signed [31:0] d_rot_z;
    logic signed [31:0] d_trans_x;
    logic signed [31:0] d_trans_y;
    logic signed [31:0] d_trans_z;
    logic               saturated;
    logic               invalid_depth;
    logic               last_row;
  } spj_out_word_t;

  // row codes
  localparam logic [1:0] ROW_LU = 2'd0;
  localparam logic [1:0] ROW_LV = 2'd1;
  localparam logic [1:0] ROW_RU = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
  localparam logic [1:0] CFG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] CFG_BASELINE = 2'd2;

  // five nonzero entries per row, one divider lane each
  localparam int LANES     = 5;
  localparam int DIV_STEPS = 32;
  // lanes whose denominator is z rather than z^2
  localparam logic [LANES-1:0] LANE_DEN_Z = 5'b01100;

  localparam logic [63:0] ONE_Q16 = 64'd65536;
  localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIM = 32'h8000_0000;

endpackage

### rtl/core/stereo_pose_projection_jacobian.sv
// Top level of the stereo pose projection Jacobian core.
// Depends on spj_pkg for word types, row codes and lane constants.
`timescale 1ns / 1ps

// One camera-frame point (Q16.16) goes in, three rows of the 3x6 stereo
// reprojection Jacobian come out: left u, left v, then right u, each row on
// out_valid for one cycle, on consecutive cycles. The core takes a new point
// once the rows of the last one have all entered the pipeline, before they
// come out: busy stays high after a point is accepted while the row
// sequencer feeds the remaining rows into the pipeline, set by the single
// result channel moving one row a cycle. The pipeline never stalls,
// since the receiver takes every word as it comes. Inside, five divider
// lanes run side by side, one per nonzero entry of a row: operand products,
// a multiply by the focal length split in two 32-bit halves, a rounding bias,
// an overflow precheck and then a 32-stage restoring divider, one quotient
// bit per stage. Entries are rounded to nearest, ties away from zero, and
// clipped to 32 bits with saturated set. A depth of zero or less gives zero
// rows flagged invalid_depth. Write the focal lengths and baseline only
// while no point is in flight.
module stereo_pose_projection_jacobian
  import spj_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spj_in_word_t  in_word,
  output logic          out_valid,
  output spj_out_word_t out_word,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [30:0]   cfg_data
);

  // configuration
  logic [30:0] fx_r, fy_r, b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= '0;
      fy_r <= '0;
      b_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X:  fx_r <= cfg_data;
        CFG_FOCAL_Y:  fy_r <= cfg_data;
        CFG_BASELINE: b_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // row sequencer: hold the point, issue one row a cycle
  logic        accept;
  logic        act_r, act_nxt;
  logic [1:0]  row_r, row_nxt;
  logic [31:0] x_r, y_r, z_r;

  assign busy   = !rst_n || (act_r && (row_r != ROW_RU));
  assign accept = start && !busy;

  always_comb begin
    act_nxt = act_r;
    row_nxt = row_r;
    if (act_r) begin
      if (row_r == ROW_RU) act_nxt = 1'b0;
      else row_nxt = row_r + 2'd1;
    end
    if (accept) begin
      act_nxt = 1'b1;
      row_nxt = ROW_LU;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= ROW_LU;
    end else begin
      act_r <= act_nxt;
      row_r <= row_nxt;
    end
    if (accept) begin
      x_r <= in_word.cam_x;
      y_r <= in_word.cam_y;
      z_r <= in_word.cam_z;
    end
  end

  // stage 1: magnitudes and x minus baseline
  logic        s1_v_r, s1_bad_r, s1_nx_r, s1_ny_r, s1_nxb_r;
  logic [1:0]  s1_row_r;
  logic [31:0] s1_ax_r, s1_ay_r, s1_axb_r;
  logic [30:0] s1_uz_r;
  logic [33:0] xb, xb_neg;

  assign xb     = {{2{x_r[31]}}, x_r} - {3'b000, b_r};
  assign xb_neg = 34'd0 - xb;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= act_r;
    s1_row_r <= row_r;
    s1_bad_r <= z_r[31] || (z_r == 32'd0);
    s1_nx_r  <= x_r[31];
    s1_ny_r  <= y_r[31];
    s1_nxb_r <= xb[33];
    s1_ax_r  <= x_r[31] ? (32'd0 - x_r) : x_r;
    s1_ay_r  <= y_r[31] ? (32'd0 - y_r) : y_r;
    s1_axb_r <= xb[33] ? xb_neg[31:0] : xb[31:0];
    s1_uz_r  <= z_r[30:0];
  end

  // stage 2: 32x32 products
  logic        s2_v_r, s2_bad_r, s2_nx_r, s2_ny_r, s2_nxb_r;
  logic [1:0]  s2_row_r;
  logic [31:0] s2_ax_r, s2_ay_r, s2_axb_r;
  logic [30:0] s2_uz_r;
  logic [61:0] s2_z2_r;
  logic [63:0] s2_pxx_r, s2_pyy_r, s2_pxy_r, s2_pxb_r, s2_pyb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
    s2_row_r <= s1_row_r;
    s2_bad_r <= s1_bad_r;
    s2_nx_r  <= s1_nx_r;
    s2_ny_r  <= s1_ny_r;
    s2_nxb_r <= s1_nxb_r;
    s2_ax_r  <= s1_ax_r;
    s2_ay_r  <= s1_ay_r;
    s2_axb_r <= s1_axb_r;
    s2_uz_r  <= s1_uz_r;
    s2_z2_r  <= 62'(s1_uz_r) * 62'(s1_uz_r);
    s2_pxx_r <= 64'(s1_ax_r) * 64'(s1_ax_r);
    s2_pyy_r <= 64'(s1_ay_r) * 64'(s1_ay_r);
    s2_pxy_r <= 64'(s1_ax_r) * 64'(s1_ay_r);
    s2_pxb_r <= 64'(s1_ax_r) * 64'(s1_axb_r);
    s2_pyb_r <= 64'(s1_ay_r) * 64'(s1_axb_r);
  end

  // stage 3: pick each lane's numerator factor and sign for this row
  logic [63:0]      a_nxt [LANES];
  logic [LANES-1:0] neg_nxt;
  logic [30:0]      bsel;
  logic [63:0]      z2w, s_sum;
  logic             pneg, sneg;

  always_comb begin
    z2w  = {2'b00, s2_z2_r};
    bsel = (s2_row_r == ROW_LV) ? fy_r : fx_r;
    // z^2 + x*(x - b), kept as magnitude and sign
    pneg = (s2_nx_r != s2_nxb_r) && (s2_pxb_r != 64'd0);
    if (!pneg) begin
      s_sum = z2w + s2_pxb_r;
      sneg  = 1'b0;
    end else if (s2_pxb_r <= z2w) begin
      s_sum = z2w - s2_pxb_r;
      sneg  = 1'b0;
    end else begin
      s_sum = s2_pxb_r - z2w;
      sneg  = 1'b1;
    end
    for (int l = 0; l < LANES; l++) a_nxt[l] = '0;
    neg_nxt = '0;
    case (s2_row_r)
      ROW_LU: begin
        a_nxt[0] = s2_pxy_r;              neg_nxt[0] = s2_nx_r != s2_ny_r;
        a_nxt[1] = z2w + s2_pxx_r;        neg_nxt[1] = 1'b1;
        a_nxt[2] = {32'd0, s2_ay_r};      neg_nxt[2] = s2_ny_r;
        a_nxt[3] = ONE_Q16;               neg_nxt[3] = 1'b1;
        a_nxt[4] = {16'd0, s2_ax_r, 16'd0}; neg_nxt[4] = s2_nx_r;
      end
      ROW_LV: begin
        a_nxt[0] = z2w + s2_pyy_r;        neg_nxt[0] = 1'b0;
        a_nxt[1] = s2_pxy_r;              neg_nxt[1] = s2_nx_r == s2_ny_r;
        a_nxt[2] = {32'd0, s2_ax_r};      neg_nxt[2] = !s2_nx_r;
        a_nxt[3] = ONE_Q16;               neg_nxt[3] = 1'b1;
        a_nxt[4] = {16'd0, s2_ay_r, 16'd0}; neg_nxt[4] = s2_ny_r;
      end
      ROW_RU: begin
        a_nxt[0] = s2_pyb_r;              neg_nxt[0] = s2_ny_r != s2_nxb_r;
        a_nxt[1] = s_sum;                 neg_nxt[1] = !sneg;
        a_nxt[2] = {32'd0, s2_ay_r};      neg_nxt[2] = s2_ny_r;
        a_nxt[3] = ONE_Q16;               neg_nxt[3] = 1'b1;
        a_nxt[4] = {16'd0, s2_axb_r, 16'd0}; neg_nxt[4] = s2_nxb_r;
      end
      default: ;
    endcase
  end

  logic             s3_v_r, s3_bad_r;
  logic [1:0]       s3_row_r;
  logic [63:0]      s3_a_r [LANES];
  logic [LANES-1:0] s3_neg_r;
  logic [30:0]      s3_b_r, s3_uz_r;
  logic [61:0]      s3_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
    s3_row_r <= s2_row_r;
    s3_bad_r <= s2_bad_r;
    s3_neg_r <= neg_nxt;
    s3_b_r   <= bsel;
    s3_uz_r  <= s2_uz_r;
    s3_z2_r  <= s2_z2_r;
    for (int l = 0; l < LANES; l++) s3_a_r[l] <= a_nxt[l];
  end

  // stage 4: multiply by focal length in two halves
  logic             s4_v_r, s4_bad_r;
  logic [1:0]       s4_row_r;
  logic [62:0]      s4_plo_r [LANES];
  logic [62:0]      s4_phi_r [LANES];
  logic [LANES-1:0] s4_neg_r;
  logic [30:0]      s4_uz_r;
  logic [61:0]      s4_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= s3_v_r;
    s4_row_r <= s3_row_r;
    s4_bad_r <= s3_bad_r;
    s4_neg_r <= s3_neg_r;
    s4_uz_r  <= s3_uz_r;
    s4_z2_r  <= s3_z2_r;
    for (int l = 0; l < LANES; l++) begin
      s4_plo_r[l] <= 63'(s3_a_r[l][31:0]) * 63'(s3_b_r);
      s4_phi_r[l] <= 63'(s3_a_r[l][63:32]) * 63'(s3_b_r);
    end
  end

  // stage 5: combine halves into the full numerator
  logic             s5_v_r, s5_bad_r;
  logic [1:0]       s5_row_r;
  logic [94:0]      s5_n_r [LANES];
  logic [LANES-1:0] s5_neg_r;
  logic [30:0]      s5_uz_r;
  logic [61:0]      s5_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else s5_v_r <= s4_v_r;
    s5_row_r <= s4_row_r;
    s5_bad_r <= s4_bad_r;
    s5_neg_r <= s4_neg_r;
    s5_uz_r  <= s4_uz_r;
    s5_z2_r  <= s4_z2_r;
    for (int l = 0; l < LANES; l++)
      s5_n_r[l] <= {32'd0, s4_plo_r[l]} + {s4_phi_r[l], 32'd0};
  end

  // stage 6: rounding bias, 2N + den, so the floor of (2N + den) / 2den
  // is the quotient rounded half away from zero
  logic             s6_v_r, s6_bad_r;
  logic [1:0]       s6_row_r;
  logic [96:0]      s6_np_r [LANES];
  logic [LANES-1:0] s6_neg_r;
  logic [30:0]      s6_uz_r;
  logic [61:0]      s6_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else s6_v_r <= s5_v_r;
    s6_row_r <= s5_row_r;
    s6_bad_r <= s5_bad_r;
    s6_neg_r <= s5_neg_r;
    s6_uz_r  <= s5_uz_r;
    s6_z2_r  <= s5_z2_r;
    for (int l = 0; l < LANES; l++)
      s6_np_r[l] <= {1'b0, s5_n_r[l], 1'b0} +
                    (LANE_DEN_Z[l] ? {66'd0, s5_uz_r} : {35'd0, s5_z2_r});
  end

  // stage 7 and the divider: index 0 holds the precheck result,
  // index d+1 the word after quotient bit d
  logic             dv_v_r    [DIV_STEPS+1];
  logic             dv_bad_r  [DIV_STEPS+1];
  logic [1:0]       dv_row_r  [DIV_STEPS+1];
  logic [31:0]      dv_d2z_r  [DIV_STEPS+1];
  logic [62:0]      dv_d2zz_r [DIV_STEPS+1];
  logic [LANES-1:0] dv_neg_r  [DIV_STEPS+1];
  logic [LANES-1:0] dv_sat_r  [DIV_STEPS+1];
  logic [62:0]      dv_rem_r  [DIV_STEPS+1][LANES];
  logic [31:0]      dv_lo_r   [DIV_STEPS+1][LANES];

  logic [96:0]      pre_lim [LANES];
  logic [62:0]      dv_den  [DIV_STEPS][LANES];
  logic [63:0]      dv_sh   [DIV_STEPS][LANES];
  logic [63:0]      dv_diff [DIV_STEPS][LANES];
  logic             dv_ge   [DIV_STEPS][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++)
      pre_lim[l] = LANE_DEN_Z[l] ? {33'd0, s6_uz_r, 33'd0} : {2'd0, s6_z2_r, 33'd0};
    for (int d = 0; d < DIV_STEPS; d++) begin
      for (int l = 0; l < LANES; l++) begin
        dv_den[d][l]  = LANE_DEN_Z[l] ? {31'd0, dv_d2z_r[d]} : dv_d2zz_r[d];
        dv_sh[d][l]   = {dv_rem_r[d][l], dv_lo_r[d][l][31]};
        dv_ge[d][l]   = dv_sh[d][l] >= {1'b0, dv_den[d][l]};
        dv_diff[d][l] = dv_sh[d][l] - {1'b0, dv_den[d][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d <= DIV_STEPS; d++) dv_v_r[d] <= 1'b0;
    end else begin
      dv_v_r[0] <= s6_v_r;
      for (int d = 0; d < DIV_STEPS; d++) dv_v_r[d+1] <= dv_v_r[d];
    end
    // precheck: a quotient of 2^32 or more clips outright
    dv_bad_r[0]  <= s6_bad_r;
    dv_row_r[0]  <= s6_row_r;
    dv_neg_r[0]  <= s6_neg_r;
    dv_d2z_r[0]  <= {s6_uz_r, 1'b0};
    dv_d2zz_r[0] <= {s6_z2_r, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      dv_sat_r[0][l] <= s6_np_r[l] >= pre_lim[l];
      dv_rem_r[0][l] <= s6_np_r[l][94:32];
      dv_lo_r[0][l]  <= s6_np_r[l][31:0];
    end
    // one restoring step per stage; quotient bits shift into the low word
    for (int d = 0; d < DIV_STEPS; d++) begin
      dv_bad_r[d+1]  <= dv_bad_r[d];
      dv_row_r[d+1]  <= dv_row_r[d];
      dv_neg_r[d+1]  <= dv_neg_r[d];
      dv_sat_r[d+1]  <= dv_sat_r[d];
      dv_d2z_r[d+1]  <= dv_d2z_r[d];
      dv_d2zz_r[d+1] <= dv_d2zz_r[d];
      for (int l = 0; l < LANES; l++) begin
        dv_rem_r[d+1][l] <= dv_ge[d][l] ? dv_diff[d][l][62:0] : dv_sh[d][l][62:0];
        dv_lo_r[d+1][l]  <= {dv_lo_r[d][l][30:0], dv_ge[d][l]};
      end
    end
  end

  // final: clip, apply sign, place lanes into the row word
  logic [31:0]      fin_lim [LANES];
  logic [31:0]      fin_mag [LANES];
  logic [31:0]      fin_val [LANES];
  logic [LANES-1:0] fin_clip;
  spj_out_word_t    out_nxt;
  logic             out_valid_r;
  spj_out_word_t    out_word_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fin_lim[l]  = dv_neg_r[DIV_STEPS][l] ? NEG_LIM : POS_LIM;
      fin_clip[l] = dv_sat_r[DIV_STEPS][l] || (dv_lo_r[DIV_STEPS][l] > fin_lim[l]);
      fin_mag[l]  = fin_clip[l] ? fin_lim[l] : dv_lo_r[DIV_STEPS][l];
      fin_val[l]  = dv_neg_r[DIV_STEPS][l] ? (32'd0 - fin_mag[l]) : fin_mag[l];
    end
    out_nxt               = '0;
    out_nxt.row_index     = dv_row_r[DIV_STEPS];
    out_nxt.last_row      = dv_row_r[DIV_STEPS] == ROW_RU;
    out_nxt.invalid_depth = dv_bad_r[DIV_STEPS];
    if (!dv_bad_r[DIV_STEPS]) begin
      out_nxt.saturated = |fin_clip;
      out_nxt.d_rot_x   = fin_val[0];
      out_nxt.d_rot_y   = fin_val[1];
      out_nxt.d_rot_z   = fin_val[2];
      if (dv_row_r[DIV_STEPS] == ROW_LV) out_nxt.d_trans_y = fin_val[3];
      else out_nxt.d_trans_x = fin_val[3];
      out_nxt.d_trans_z = fin_val[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dv_v_r[DIV_STEPS];
    out_word_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 busy ##1 !busy)
    else $error("sequencer did not hold off for two rows");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last_row == (out_word.row_index == ROW_RU)))
    else $error("last_row does not match row_index");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.invalid_depth |->
      !out_word.saturated && (out_word.d_rot_x == 32'sd0) &&
      (out_word.d_trans_z == 32'sd0))
    else $error("invalid depth row not zeroed");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.row_index == ROW_LU) |=>
      out_valid && (out_word.row_index == ROW_LV))
    else $error("left v row did not follow left u row");

endmodule

### tb/spj_checker.sv
// Checker for the stereo pose projection Jacobian core: predicts rows and compares.
// Depends on spj_pkg for word types, row codes and register indexes.
`timescale 1ns / 1ps

module spj_checker
  import spj_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  spj_in_word_t  in_word,
  input  logic          out_valid,
  input  spj_out_word_t out_word,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [30:0]   cfg_data,
  output int            fail_count,
  output int            rows_pending
);

  logic [30:0] fx_q, fy_q, base_q;
  spj_out_word_t row_queue[$];

  // sign * a * b / den, rounded to nearest (ties away), clipped to 32 bits
  function automatic logic [31:0] q16_entry(bit neg, logic [63:0] a, logic [63:0] b,
                                            logic [63:0] den, inout bit sat);
    logic [127:0] num, quo, rem, lim;
    num = {64'd0, a} * {64'd0, b};
    quo = num / {64'd0, den};
    rem = num % {64'd0, den};
    if ((rem << 1) >= {64'd0, den}) quo = quo + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (quo > lim) begin
      quo = lim;
      sat = 1'b1;
    end
    return neg ? (32'd0 - quo[31:0]) : quo[31:0];
  endfunction

  function automatic void jacobian_rows(spj_in_word_t w, output spj_out_word_t rows[3]);
    logic signed [63:0] xs, ys, zs, xbs;
    logic [63:0] ax, ay, uz, z2, axb, p, s, fx, fy;
    bit nx, ny, nxb, pneg, sneg, s0, s1, s2, bad;
    xs = w.cam_x; ys = w.cam_y; zs = w.cam_z;
    bad = (zs <= 0);
    for (int r = 0; r < 3; r++) begin
      rows[r] = '0;
      rows[r].row_index = (r == 0) ? ROW_LU : (r == 1) ? ROW_LV : ROW_RU;
      rows[r].invalid_depth = bad;
      rows[r].last_row = (r == 2);
    end
    if (bad) return;
    s0 = 0; s1 = 0; s2 = 0;
    nx = xs < 0; ny = ys < 0;
    ax = nx ? -xs : xs;
    ay = ny ? -ys : ys;
    uz = zs;
    z2 = uz * uz;
    xbs = xs - $signed({33'd0, base_q});
    nxb = xbs < 0;
    axb = nxb ? -xbs : xbs;
    fx = {33'd0, fx_q};
    fy = {33'd0, fy_q};
    rows[0].d_rot_x   = q16_entry(nx != ny, ax * ay, fx, z2, s0);
    rows[0].d_rot_y   = q16_entry(1'b1, z2 + ax * ax, fx, z2, s0);
    rows[0].d_rot_z   = q16_entry(ny, ay, fx, uz, s0);
    rows[0].d_trans_x = q16_entry(1'b1, fx, ONE_Q16, uz, s0);
    rows[0].d_trans_z = q16_entry(nx, ax << 16, fx, z2, s0);
    rows[1].d_rot_x   = q16_entry(1'b0, z2 + ay * ay, fy, z2, s1);
    rows[1].d_rot_y   = q16_entry(nx == ny, ax * ay, fy, z2, s1);
    rows[1].d_rot_z   = q16_entry(!nx, ax, fy, uz, s1);
    rows[1].d_trans_y = q16_entry(1'b1, fy, ONE_Q16, uz, s1);
    rows[1].d_trans_z = q16_entry(ny, ay << 16, fy, z2, s1);
    // z^2 + x*(x - b), signed
    p = ax * axb;
    pneg = (nx != nxb) && (p != 0);
    if (!pneg) begin
      s = z2 + p; sneg = 0;
    end else if (p <= z2) begin
      s = z2 - p; sneg = 0;
    end else begin
      s = p - z2; sneg = 1;
    end
    rows[2].d_rot_x   = q16_entry(ny != nxb, ay * axb, fx, z2, s2);
    rows[2].d_rot_y   = q16_entry(!sneg, s, fx, z2, s2);
    rows[2].d_rot_z   = q16_entry(ny, ay, fx, uz, s2);
    rows[2].d_trans_x = q16_entry(1'b1, fx, ONE_Q16, uz, s2);
    rows[2].d_trans_z = q16_entry(nxb, axb << 16, fx, z2, s2);
    rows[0].saturated = s0;
    rows[1].saturated = s1;
    rows[2].saturated = s2;
  endfunction

  assign rows_pending = row_queue.size();

  always @(posedge clk) begin
    spj_out_word_t rows[3];
    spj_out_word_t want;
    if (!rst_n) begin
      fx_q <= '0; fy_q <= '0; base_q <= '0;
      fail_count <= 0;
    end else begin
      // check rows first: they come from points accepted long before
      if (out_valid) begin
        if (row_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected row word: %p", out_word);
          fail_count <= fail_count + 1;
        end else begin
          want = row_queue.pop_front();
          if (out_word !== want) begin
            if (fail_count < 10) $display("row mismatch: expected %p actual %p", want, out_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        jacobian_rows(in_word, rows);
        for (int r = 0; r < 3; r++) row_queue.push_back(rows[r]);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOCAL_X:  fx_q <= cfg_data;
          CFG_FOCAL_Y:  fy_q <= cfg_data;
          CFG_BASELINE: base_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb_stereo_pose_projection_jacobian.sv
// Testbench top for the stereo pose projection Jacobian core: stimulus and verdict.
// Depends on spj_pkg, the core and spj_checker.
`timescale 1ns / 1ps

module tb_stereo_pose_projection_jacobian;
  import spj_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  spj_in_word_t in_word = '0;
  logic out_valid;
  spj_out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  int fail_count, rows_pending;
  int cycles = 0;
  int idle_pct = 0;

  always #1 clk = ~clk;

  stereo_pose_projection_jacobian dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spj_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .rows_pending(rows_pending)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_stereo_pose_projection_jacobian NOT OK");
      $finish;
    end
  end

  // Offer one point word; hold start until an edge sees busy low.
  // Random idle cycles go in front of the word, never in the middle of an offer.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= '{cam_x: x, cam_y: y, cam_z: z};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain all rows, let the pipeline settle, then write all three registers.
  task automatic load_config(logic [30:0] fx, logic [30:0] fy, logic [30:0] b);
    start <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_FOCAL_X; cfg_data <= fx;
    @(posedge clk);
    cfg_index <= CFG_FOCAL_Y; cfg_data <= fy;
    @(posedge clk);
    cfg_index <= CFG_BASELINE; cfg_data <= b;
    @(posedge clk);
    // the spare index must be ignored
    cfg_index <= CFG_UNUSED; cfg_data <= 31'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random point: mostly realistic scene geometry, some raw noise,
  // some non-positive depths and some tiny positive depths.
  task automatic send_random_point();
    int pick;
    logic signed [31:0] x, y, z;
    pick = $urandom_range(99);
    if (pick < 60) begin
      x = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      y = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      z = $urandom_range(32'h0040_0000, 1);
    end else if (pick < 85) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else if (pick < 95) begin
      x = $urandom; y = $urandom; z = -$signed($urandom_range(32'h7FFF_FFFF, 0));
    end else begin
      x = $urandom; y = $urandom; z = $urandom_range(8, 1);
    end
    send_point(x, y, z);
  endtask

  initial begin
    logic [30:0] max31;
    max31 = 31'h7FFF_FFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: typical stereo rig, then the field extremes and bad depths.
    load_config(31'(500 << 16), 31'(480 << 16), 31'(7864));
    send_point(32'sh0001_0000, 32'sh0000_8000, 32'sh0005_0000);
    send_point(-32'sh0002_0000, 32'sh0001_8000, 32'sh0003_0000);
    send_point(32'sh0000_1EB8, -32'sh0000_4000, 32'sh0001_0000);  // x equals baseline
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sd1);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sd0, 32'sd0, 32'sh7FFF_FFFF);
    send_point(32'sd0, 32'sd0, 32'sd0);                            // zero depth
    send_point(32'sh0001_0000, 32'sh0001_0000, -32'sd1);           // negative depth
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);    // most negative depth
    send_point(32'sd1, -32'sd1, 32'sd1);
    load_config(max31, max31, max31);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sh7FFF_FFFF, -32'sd5, 32'sh7FFF_FFFF);
    send_point(32'sd0, 32'sd0, 32'sd1);
    load_config('0, '0, '0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);

    // Random: three idle regimes, two register settings in each.
    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 36 : (seg < 4) ? 56 : 0;
      case (seg)
        0: load_config(31'(600 << 16), 31'(600 << 16), 31'(3 << 14));
        1: load_config(31'($urandom), 31'($urandom), 31'($urandom));
        2: load_config(max31, 31'd0, max31);
        3: load_config(31'($urandom_range(2000 << 16)), 31'($urandom_range(2000 << 16)),
                       31'($urandom_range(1 << 17)));
        4: load_config(31'd0, max31, 31'd0);
        default: load_config(31'(400 << 16), 31'(420 << 16), 31'(1 << 15));
      endcase
      repeat (76) send_random_point();
    end

    start <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("tb_stereo_pose_projection_jacobian OK");
    end else begin
      $display("tb_stereo_pose_projection_jacobian NOT OK");
    end
    $finish;
  end

endmodule
